[sv/gem_pkg.sv]
// Shared types and constants of the masked grayscale erosion block.
// Used by gem_window, grayscale_erosion_masked and gem_checker; depends on nothing.
package gem_pkg;

  // Pixel and store entry widths (entry = pixel plus mask bit on top)
  localparam int PIX_W    = 8;
  localparam int ENTRY_W  = PIX_W + 1;
  localparam int MASK_BIT = PIX_W;

  // Configuration register widths
  localparam int CFG_LEN_W  = 11;
  localparam int CFG_CNT_W  = 13;
  localparam int HALF_W     = 2;
  localparam int ELEM_W     = 49;
  localparam int ELEM_IDX_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ELEM_W;

  // Column position and its limit
  localparam int COL_W            = 12;
  localparam int MAX_COLUMN_COUNT = 4096;

  // Default sizes handed to the top level
  localparam int DEF_MAX_COLUMN_LENGTH = 1024;
  localparam int DEF_MAX_HALF_SIZE     = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ROWS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_COLS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BITS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE   = 3'd5;

  // Register reset values
  localparam logic [CFG_LEN_W-1:0] RST_COLUMN_LENGTH = 11'd1024;
  localparam logic [CFG_CNT_W-1:0] RST_COLUMN_COUNT  = 13'd1024;
  localparam logic [HALF_W-1:0]    RST_HALF_ROWS     = 2'd1;
  localparam logic [HALF_W-1:0]    RST_HALF_COLS     = 2'd1;
  localparam logic [ELEM_W-1:0]    RST_ELEMENT_BITS  = 49'd511;
  localparam logic                 RST_MASK_ENABLE   = 1'b0;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } gem_ctrl_t;

  // Effective configuration seen by the window datapath
  typedef struct packed {
    logic [HALF_W-1:0] half_rows;
    logic [HALF_W-1:0] half_cols;
    logic [ELEM_W-1:0] element_bits;
    logic              mask_enable;
  } gem_cfg_t;

endpackage

[sv/gem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gem_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/gem_window.sv]
// Window datapath: row shift line, structuring-element select, two-level minimum.
// Depends on gem_pkg.
module gem_window #(
  parameter int MAX_HALF_SIZE = gem_pkg::DEF_MAX_HALF_SIZE
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic                                                     en,
  input  gem_pkg::gem_ctrl_t                                       in_ctrl,
  input  logic [2*MAX_HALF_SIZE:0][gem_pkg::ENTRY_W-1:0]           row_vec,
  input  gem_pkg::gem_cfg_t                                        cfg,
  output gem_pkg::gem_ctrl_t                                       out_ctrl,
  output logic [gem_pkg::PIX_W-1:0]                                out_pixel
);
  import gem_pkg::*;

  localparam int WIN = 2 * MAX_HALF_SIZE + 1;

  // Element select per window position, window[k][d] = row r-k, column c-d
  logic [WIN-1:0][WIN-1:0]              sel_next;
  logic [WIN-1:0][WIN-1:0]              sel;
  logic [ELEM_IDX_W-1:0]                two_p;
  logic [ELEM_IDX_W-1:0]                two_q;

  // Shift line of row vectors and stage registers
  logic [WIN-1:0][WIN-1:0][ENTRY_W-1:0] win;
  gem_ctrl_t                            s2_ctrl;
  gem_ctrl_t                            s3_ctrl;
  gem_ctrl_t                            s4_ctrl;
  logic [WIN-1:0][WIN-1:0][PIX_W-1:0]   masked;
  logic [ENTRY_W-1:0]                   centre;
  logic [WIN-1:0][WIN-1:0][PIX_W-1:0]   s3_masked;
  logic [PIX_W-1:0]                     s3_centre;
  logic                                 s3_keep;
  logic [WIN-1:0][PIX_W-1:0]            row_min;
  logic [WIN-1:0][PIX_W-1:0]            s4_row_min;
  logic [PIX_W-1:0]                     s4_centre;
  logic                                 s4_keep;
  logic [PIX_W-1:0]                     least;

  assign two_p = ELEM_IDX_W'({cfg.half_rows, 1'b0});
  assign two_q = ELEM_IDX_W'({cfg.half_cols, 1'b0});

  // Map each window position to its element bit
  for (genvar k = 0; k < WIN; k++) begin : g_sel_row
    for (genvar d = 0; d < WIN; d++) begin : g_sel_col
      logic [ELEM_IDX_W-1:0] dr;
      logic [ELEM_IDX_W-1:0] dc;
      logic [ELEM_IDX_W-1:0] idx;
      assign dr  = two_p - ELEM_IDX_W'(k);
      assign dc  = two_q - ELEM_IDX_W'(d);
      assign idx = ELEM_IDX_W'(dr + (two_p + ELEM_IDX_W'(1)) * dc);
      assign sel_next[k][d] = (ELEM_IDX_W'(k) <= two_p) && (ELEM_IDX_W'(d) <= two_q) &&
                              cfg.element_bits[idx];
    end
  end

  // Hold the decoded select; the user must change configuration only while idle
  always_ff @(posedge clk) begin
    sel <= sel_next;
  end

  // Stage 2: shift each transaction's row vector into the window
  always_ff @(posedge clk) begin
    if (en && in_ctrl.valid) begin
      win[0] <= row_vec;
      for (int k = 1; k < WIN; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  // Pick the centre entry
  always_comb begin
    centre = '0;
    for (int k = 0; k < WIN; k++) begin
      for (int d = 0; d < WIN; d++) begin
        if (k == int'(cfg.half_rows) && d == int'(cfg.half_cols)) begin
          centre = win[k][d];
        end
      end
    end
  end

  // Drop unselected neighbours to the neutral value
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int d = 0; d < WIN; d++) begin
        masked[k][d] = sel[k][d] ? win[k][d][PIX_W-1:0] : {PIX_W{1'b1}};
      end
    end
  end

  // Stage 3 payload
  always_ff @(posedge clk) begin
    if (en) begin
      s3_masked <= masked;
      s3_centre <= centre[PIX_W-1:0];
      s3_keep   <= cfg.mask_enable && !centre[MASK_BIT];
    end
  end

  // Minimum along each window row
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      row_min[k] = s3_masked[k][0];
      for (int d = 1; d < WIN; d++) begin
        if (s3_masked[k][d] < row_min[k]) begin
          row_min[k] = s3_masked[k][d];
        end
      end
    end
  end

  // Stage 4 payload
  always_ff @(posedge clk) begin
    if (en) begin
      s4_row_min <= row_min;
      s4_centre  <= s3_centre;
      s4_keep    <= s3_keep;
    end
  end

  // Advance control; only window-completing transactions go past stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
      s3_ctrl <= '0;
      s4_ctrl <= '0;
    end else if (en) begin
      s2_ctrl <= in_ctrl;
      s3_ctrl <= '{valid: s2_ctrl.valid && s2_ctrl.emit, emit: s2_ctrl.emit,
                   last: s2_ctrl.last};
      s4_ctrl <= s3_ctrl;
    end
  end

  // Fold row minima with the centre, pass the centre through when masked off
  always_comb begin
    least = s4_centre;
    for (int k = 0; k < WIN; k++) begin
      if (s4_row_min[k] < least) begin
        least = s4_row_min[k];
      end
    end
  end

  assign out_pixel = s4_keep ? s4_centre : least;
  assign out_ctrl  = s4_ctrl;

endmodule

[sv/grayscale_erosion_masked.sv]
// Channel   Group     Fields (low bit first)         Accepted when
// input     s_*       tdata: pixel_in; tuser: mask   s_tvalid && s_tready
// output    m_*       tdata: pixel_out; tlast: last  m_tvalid && m_tready
// config    cfg_*     index selects register         cfg_we
//
// One pixel per clock while s_tready is high. A result reaches the output register
// from its accepted pixel through column RAM read, window shift, element select, row
// minimum and final minimum. Synchronous reset clears control and the configuration
// registers only; the column store needs no clearing pass. s_tready drops only while
// the one-entry skid behind the output register is full.
//
// Top level of the masked grayscale erosion block.
// Depends on gem_pkg, gem_ram and gem_window.
module grayscale_erosion_masked #(
  parameter int MAX_COLUMN_LENGTH = gem_pkg::DEF_MAX_COLUMN_LENGTH,
  parameter int MAX_HALF_SIZE     = gem_pkg::DEF_MAX_HALF_SIZE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gem_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel_in
  input  logic                             s_tuser,   // [0] mask_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gem_pkg::PIX_W-1:0]        m_tdata,   // [7:0] pixel_out
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [gem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gem_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gem_pkg::*;

  localparam int SLOT_COUNT = 2 * MAX_HALF_SIZE + 1;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int ROW_W      = $clog2(MAX_COLUMN_LENGTH);
  localparam int LEN_CMP_W  = ($clog2(MAX_COLUMN_LENGTH + 1) > CFG_LEN_W) ?
                              $clog2(MAX_COLUMN_LENGTH + 1) : CFG_LEN_W;

  // Configuration registers
  logic [CFG_LEN_W-1:0]  column_length;
  logic [CFG_CNT_W-1:0]  column_count;
  logic [HALF_W-1:0]     half_rows;
  logic [HALF_W-1:0]     half_cols;
  logic [ELEM_W-1:0]     element_bits;
  logic                  mask_enable;

  // Effective sizes
  logic [LEN_CMP_W-1:0]  len_ext;
  logic [LEN_CMP_W-1:0]  rows_eff;
  logic [CFG_CNT_W-1:0]  cols_eff;
  logic [ROW_W-1:0]      row_last;
  logic [COL_W-1:0]      col_last;
  gem_cfg_t              cfg;

  // Positions
  logic [ROW_W-1:0]      row_pos;
  logic [COL_W-1:0]      col_pos;
  logic [SLOT_W-1:0]     slot;
  logic                  accept;
  logic                  en;
  logic                  emit_now;
  logic                  last_now;

  // Column store and stage 1
  logic [SLOT_COUNT-1:0][ENTRY_W-1:0] ram_q;
  gem_ctrl_t                          s1_ctrl;
  logic [ENTRY_W-1:0]                 s1_entry;
  logic [SLOT_W-1:0]                  s1_slot;
  logic [SLOT_COUNT-1:0][ENTRY_W-1:0] row_vec;

  // Window result and output stage
  gem_ctrl_t             win_ctrl;
  logic [PIX_W-1:0]      win_pixel;
  logic                  fire;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel;
  logic                  out_last;
  logic                  skid_valid;
  logic [PIX_W-1:0]      skid_pixel;
  logic                  skid_last;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_length <= RST_COLUMN_LENGTH;
      column_count  <= RST_COLUMN_COUNT;
      half_rows     <= RST_HALF_ROWS;
      half_cols     <= RST_HALF_COLS;
      element_bits  <= RST_ELEMENT_BITS;
      mask_enable   <= RST_MASK_ENABLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_LENGTH: column_length <= cfg_data[CFG_LEN_W-1:0];
        REG_COLUMN_COUNT:  column_count  <= cfg_data[CFG_CNT_W-1:0];
        REG_HALF_ROWS:     half_rows     <= cfg_data[HALF_W-1:0];
        REG_HALF_COLS:     half_cols     <= cfg_data[HALF_W-1:0];
        REG_ELEMENT_BITS:  element_bits  <= cfg_data[ELEM_W-1:0];
        REG_MASK_ENABLE:   mask_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate sizes into range
  assign len_ext  = LEN_CMP_W'(column_length);
  assign rows_eff = (len_ext == '0) ? LEN_CMP_W'(1) :
                    (len_ext > LEN_CMP_W'(MAX_COLUMN_LENGTH)) ? LEN_CMP_W'(MAX_COLUMN_LENGTH) :
                    len_ext;
  assign cols_eff = (column_count == '0) ? CFG_CNT_W'(1) :
                    (column_count > CFG_CNT_W'(MAX_COLUMN_COUNT)) ?
                    CFG_CNT_W'(MAX_COLUMN_COUNT) : column_count;
  assign row_last = ROW_W'(rows_eff - LEN_CMP_W'(1));
  assign col_last = COL_W'(cols_eff - CFG_CNT_W'(1));

  assign cfg.half_rows    = (half_rows > HALF_W'(MAX_HALF_SIZE)) ? HALF_W'(MAX_HALF_SIZE) :
                            half_rows;
  assign cfg.half_cols    = (half_cols > HALF_W'(MAX_HALF_SIZE)) ? HALF_W'(MAX_HALF_SIZE) :
                            half_cols;
  assign cfg.element_bits = element_bits;
  assign cfg.mask_enable  = mask_enable;

  // Handshake: stall the input and the pipeline while the skid entry is occupied
  assign en       = !skid_valid;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  assign emit_now = (row_pos >= ROW_W'({cfg.half_rows, 1'b0})) &&
                    (col_pos >= COL_W'({cfg.half_cols, 1'b0}));
  assign last_now = (row_pos == row_last) && (col_pos == col_last);

  // Advance row, column and store slot; any register write starts a new image
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_pos <= '0;
      col_pos <= '0;
      slot    <= '0;
    end else if (accept) begin
      if (row_pos == row_last) begin
        row_pos <= '0;
        if (col_pos == col_last) begin
          col_pos <= '0;
          slot    <= '0;
        end else begin
          col_pos <= col_pos + COL_W'(1);
          slot    <= (slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot + SLOT_W'(1);
        end
      end else begin
        row_pos <= row_pos + ROW_W'(1);
      end
    end
  end

  // One column RAM per slot; all read the current row, one is written
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    gem_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_COLUMN_LENGTH)
    ) u_ram (
      .clk   (clk),
      .we    (accept && (slot == SLOT_W'(i))),
      .waddr (row_pos),
      .wdata ({s_tuser, s_tdata}),
      .re    (accept),
      .raddr (row_pos),
      .rdata (ram_q[i])
    );
  end

  // Stage 1 control and payload, aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (en) begin
      s1_ctrl <= '{valid: accept, emit: emit_now, last: last_now};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_entry <= {s_tuser, s_tdata};
      s1_slot  <= slot;
    end
  end

  // Rotate RAM outputs so that lane d holds column c-d
  assign row_vec[0] = s1_entry;
  for (genvar d = 1; d < SLOT_COUNT; d++) begin : g_lane
    logic [SLOT_W:0] src;
    assign src = (s1_slot >= SLOT_W'(d)) ? {1'b0, s1_slot} - (SLOT_W+1)'(d) :
                 {1'b0, s1_slot} + (SLOT_W+1)'(SLOT_COUNT - d);
    assign row_vec[d] = ram_q[src[SLOT_W-1:0]];
  end

  gem_window #(
    .MAX_HALF_SIZE (MAX_HALF_SIZE)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctrl   (s1_ctrl),
    .row_vec   (row_vec),
    .cfg       (cfg),
    .out_ctrl  (win_ctrl),
    .out_pixel (win_pixel)
  );

  assign fire = en && win_ctrl.valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid  <= skid_valid || fire;
      skid_valid <= 1'b0;
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_pixel <= skid_pixel;
        out_last  <= skid_last;
      end else begin
        out_pixel <= win_pixel;
        out_last  <= win_ctrl.last;
      end
    end else if (fire) begin
      skid_pixel <= win_pixel;
      skid_last  <= win_ctrl.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pixel;
  assign m_tlast  = out_last;

endmodule

[sv/gem_checker.sv]
// Port-level checks for grayscale_erosion_masked, attached by bind.
// Depends on gem_pkg and the top level's port names.
module gem_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [gem_pkg::PIX_W-1:0] m_tdata,
  input logic                      m_tlast
);
  import gem_pkg::*;

  // Reset empties the output register and the skid entry
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output or skid not empty after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  // An empty output register implies the skid entry is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no output pending");

  // A taken result always frees the skid entry
  a_ready_after_take: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready)
    else $error("input still stalled after an output transaction");

  // The input side never sees a stall without a result waiting
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |-> m_tvalid)
    else $error("input stalled while output is idle");

endmodule

bind grayscale_erosion_masked gem_checker u_gem_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
